### rtl/sicp_pkg.sv
// shared types and constants for the init chunk parser
package sicp_pkg;

   // fixed header and parameter framing
   localparam logic [15:0] HDR_BYTES = 16'd16;
   localparam logic [15:0] TLV_HDR   = 16'd4;
   localparam logic [16:0] PAD_MASK  = 17'd3;

   // longest chunk value accepted
   localparam logic [16:0] MAX_CHUNK_BYTES = 17'd65535;

   // saturation value of the position counter
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_TRUNC  = 2'd1;
   localparam logic [1:0] ST_FORMAT = 2'd2;

   // parameter type codes
   localparam logic [15:0] PT_FWD_TSN    = 16'hC000;
   localparam logic [15:0] PT_EXTENSIONS = 16'h8008;
   localparam logic [15:0] PT_COOKIE     = 16'h0007;

   // chunk type codes in the extension list
   localparam logic [7:0] CT_I_DATA   = 8'h40;
   localparam logic [7:0] CT_I_FWD    = 8'hC2;
   localparam logic [7:0] CT_RECONFIG = 8'h82;

   // extension flag bit positions
   localparam int FL_FWD    = 0;
   localparam int FL_IDATA  = 1;
   localparam int FL_IFWD   = 2;
   localparam int FL_RECONF = 3;

   // per-byte control from the top level to the field trackers
   typedef struct packed {
      logic take;   // consume the current byte
      logic clear;  // chunk done, return to reset state
   } sicp_ctl_type;

endpackage

### rtl/sicp_hdr_capture.sv
// capture of the 16-byte fixed header and its zero-value checks
module sicp_hdr_capture
   import sicp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sicp_ctl_type ctl,
   input  logic [3:0]   pos,
   input  logic [7:0]   data_byte,
   output logic [63:0]  hdr0,
   output logic [63:0]  hdr1,
   output logic         fmt_err
);

   logic [63:0] hdr0_ff, hdr0_in;
   logic [63:0] hdr1_ff, hdr1_in;

   // shift the byte into the half that holds its position
   always_comb begin
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      if (ctl.take) begin
         if (pos[3] == 1'b0) begin
            hdr0_in = {hdr0_ff[55:0], data_byte};
         end else begin
            hdr1_in = {hdr1_ff[55:0], data_byte};
         end
      end
   end

   // zero tag or zero stream count on the last header byte
   always_comb begin
      fmt_err = 1'b0;
      if (ctl.take && pos == 4'd15) begin
         fmt_err = (hdr0_ff[63:32] == 32'd0) || (hdr1_ff[55:40] == 16'd0) ||
                   (hdr1_ff[39:24] == 16'd0);
      end
   end

   assign hdr0 = hdr0_in;
   assign hdr1 = hdr1_in;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         hdr0_ff <= 64'd0;
         hdr1_ff <= 64'd0;
      end else begin
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
      end
   end

endmodule

### rtl/sicp_tlv_walker.sv
// walker over the type/length/value parameters after the header
module sicp_tlv_walker
   import sicp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sicp_ctl_type ctl,
   input  logic [15:0]  pos,
   input  logic [7:0]   data_byte,
   input  logic [15:0]  value_len,
   output logic [1:0]   err,
   output logic [3:0]   flags,
   output logic [15:0]  cookie_start,
   output logic [15:0]  cookie_bytes
);

   logic [15:0] start_ff, start_in;
   logic [15:0] ptype_ff, ptype_in;
   logic [15:0] plen_ff, plen_in;
   logic [3:0]  flags_ff, flags_in;
   logic [15:0] cstart_ff, cstart_in;
   logic [15:0] cbytes_ff, cbytes_in;

   logic [15:0] rel;
   logic [15:0] room;
   logic [15:0] len_cur;
   logic [16:0] padded;
   logic [16:0] span;
   logic [16:0] pend;
   logic [1:0]  err_cur;

   assign rel  = pos - start_ff;
   assign room = value_len - start_ff;

   // field assembly and per-parameter checks
   always_comb begin
      ptype_in  = ptype_ff;
      plen_in   = plen_ff;
      flags_in  = flags_ff;
      cstart_in = cstart_ff;
      cbytes_in = cbytes_ff;
      err_cur   = ST_OK;
      len_cur   = plen_ff | {8'h00, data_byte};
      padded    = ({1'b0, plen_ff} + PAD_MASK) & ~PAD_MASK;
      if (rel == 16'd0) begin
         if (room < TLV_HDR) begin
            err_cur = ST_TRUNC;
         end else begin
            ptype_in = {data_byte, 8'h00};
         end
      end else if (rel == 16'd1) begin
         ptype_in = ptype_ff | {8'h00, data_byte};
      end else if (rel == 16'd2) begin
         plen_in = {data_byte, 8'h00};
      end else if (rel == 16'd3) begin
         plen_in = len_cur;
         padded  = ({1'b0, len_cur} + PAD_MASK) & ~PAD_MASK;
         if (len_cur < TLV_HDR || len_cur > room) begin
            err_cur = ST_FORMAT;
         end else if (ptype_ff == PT_FWD_TSN && len_cur != TLV_HDR) begin
            err_cur = ST_FORMAT;
         end else if (ptype_ff == PT_COOKIE && len_cur <= TLV_HDR) begin
            err_cur = ST_FORMAT;
         end else begin
            if (ptype_ff == PT_FWD_TSN) begin
               flags_in[FL_FWD] = 1'b1;
            end
            if (ptype_ff == PT_COOKIE) begin
               cstart_in = start_ff + TLV_HDR;
               cbytes_in = len_cur - TLV_HDR;
            end
            if (padded > {1'b0, room} && len_cur != room) begin
               err_cur = ST_TRUNC;
            end
         end
      end else if (rel < plen_ff && ptype_ff == PT_EXTENSIONS) begin
         if (data_byte == CT_I_DATA) begin
            flags_in[FL_IDATA] = 1'b1;
         end
         if (data_byte == CT_I_FWD) begin
            flags_in[FL_IFWD] = 1'b1;
         end
         if (data_byte == CT_RECONFIG) begin
            flags_in[FL_RECONF] = 1'b1;
         end
      end
   end

   // advance to the next parameter on the last padded byte of this one
   assign span = (padded > {1'b0, room}) ? {1'b0, room} : padded;
   assign pend = {1'b0, start_ff} + span;

   always_comb begin
      start_in = start_ff;
      if (rel >= 16'd3 && err_cur == ST_OK && ({1'b0, pos} + 17'd1) == pend) begin
         start_in = pos + 16'd1;
      end
   end

   assign err          = ctl.take ? err_cur : ST_OK;
   assign flags        = ctl.take ? flags_in : flags_ff;
   assign cookie_start = ctl.take ? cstart_in : cstart_ff;
   assign cookie_bytes = ctl.take ? cbytes_in : cbytes_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         start_ff  <= HDR_BYTES;
         ptype_ff  <= 16'd0;
         plen_ff   <= 16'd0;
         flags_ff  <= 4'd0;
         cstart_ff <= 16'd0;
         cbytes_ff <= 16'd0;
      end else if (ctl.take) begin
         start_ff  <= start_in;
         ptype_ff  <= ptype_in;
         plen_ff   <= plen_in;
         flags_ff  <= flags_in;
         cstart_ff <= cstart_in;
         cbytes_ff <= cbytes_in;
      end
   end

endmodule

### rtl/sctp_init_chunk_parser_unit.sv
// top level of the streaming init chunk parser
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  data_byte, byte_valid, value_len, last_byte
//   rsp      out        rsp_valid/rsp_ready  status, header fields, flags, cookie
//
// one byte item per cycle, back to back, unless a last item waits on an untaken result;
// an item is worked on while it sits in the input register, and a last item loads the
// result register at the edge it leaves, which raises rsp_valid.
// reset is synchronous and clears all control state and the parser.
// a result that is not taken holds only the next last item in the input register,
// which then closes the input; byte items ahead of it keep flowing.
module sctp_init_chunk_parser_unit
   import sicp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic [15:0] req_value_len,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_peer_tag,
   output logic [31:0] rsp_peer_window,
   output logic [15:0] rsp_outbound_count,
   output logic [15:0] rsp_inbound_count,
   output logic [31:0] rsp_first_tsn,
   output logic        rsp_forward_tsn_ok,
   output logic        rsp_interleave_ok,
   output logic        rsp_reconfig_ok,
   output logic [15:0] rsp_cookie_start,
   output logic [15:0] rsp_cookie_bytes
);

   // input register
   logic        in_vld_ff;
   logic [7:0]  data_ff;
   logic        bvalid_ff;
   logic [15:0] len_ff;
   logic        last_ff;

   // parser control state
   logic [15:0] pos_ff, pos_in;
   logic [1:0]  err_ff, err_in;

   // result register
   logic        out_vld_ff;
   logic [1:0]  status_ff;
   logic [31:0] tag_ff, wnd_ff, tsn_ff;
   logic [15:0] obc_ff, ibc_ff, cstart_ff, cbytes_ff;
   logic        fwd_ff, ilv_ff, rcf_ff;

   logic         advance;
   logic         step;
   logic         len_short, len_long;
   sicp_ctl_type hdr_ctl, tlv_ctl;
   logic [63:0]  hdr0, hdr1;
   logic         hdr_fmt;
   logic [1:0]   tlv_err;
   logic [3:0]   flags;
   logic [15:0]  cookie_start, cookie_bytes;
   logic [1:0]   status;

   // a last item waits while an untaken result sits in the result register
   assign advance   = in_vld_ff && !(last_ff && out_vld_ff && !rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff   <= req_data_byte;
         bvalid_ff <= req_byte_valid;
         len_ff    <= req_value_len;
         last_ff   <= req_last_byte;
      end
   end

   // byte gating: inside the chunk, no error yet
   assign len_short = len_ff < HDR_BYTES;
   assign len_long  = {1'b0, len_ff} > MAX_CHUNK_BYTES;
   assign step      = advance && bvalid_ff && (pos_ff < len_ff) && (err_ff == ST_OK);

   assign hdr_ctl.take  = step && !len_short && !len_long && (pos_ff < HDR_BYTES);
   assign hdr_ctl.clear = advance && last_ff;
   assign tlv_ctl.take  = step && !len_short && !len_long && (pos_ff >= HDR_BYTES);
   assign tlv_ctl.clear = advance && last_ff;

   sicp_hdr_capture u_hdr (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hdr_ctl),
      .pos       (pos_ff[3:0]),
      .data_byte (data_ff),
      .hdr0      (hdr0),
      .hdr1      (hdr1),
      .fmt_err   (hdr_fmt)
   );

   sicp_tlv_walker u_tlv (
      .clock        (clock),
      .reset        (reset),
      .ctl          (tlv_ctl),
      .pos          (pos_ff),
      .data_byte    (data_ff),
      .value_len    (len_ff),
      .err          (tlv_err),
      .flags        (flags),
      .cookie_start (cookie_start),
      .cookie_bytes (cookie_bytes)
   );

   // position counter, saturating
   always_comb begin
      pos_in = pos_ff;
      if (advance && bvalid_ff && pos_ff < POS_MAX) begin
         pos_in = pos_ff + 16'd1;
      end
   end

   // first error in byte order wins
   always_comb begin
      err_in = err_ff;
      if (step) begin
         if (len_short) begin
            err_in = ST_TRUNC;
         end else if (len_long) begin
            err_in = ST_FORMAT;
         end else if (hdr_fmt) begin
            err_in = ST_FORMAT;
         end else if (tlv_err != ST_OK) begin
            err_in = tlv_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_ff)) begin
         pos_ff <= 16'd0;
         err_ff <= ST_OK;
      end else begin
         pos_ff <= pos_in;
         err_ff <= err_in;
      end
   end

   // final status of the chunk
   always_comb begin
      status = err_in;
      if (err_in == ST_OK) begin
         if (len_short) begin
            status = ST_TRUNC;
         end else if (len_long) begin
            status = ST_FORMAT;
         end else if (pos_in < len_ff) begin
            status = ST_TRUNC;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance && last_ff) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_ff) begin
         status_ff <= status;
         if (status == ST_OK) begin
            tag_ff    <= hdr0[63:32];
            wnd_ff    <= hdr0[31:0];
            obc_ff    <= hdr1[63:48];
            ibc_ff    <= hdr1[47:32];
            tsn_ff    <= hdr1[31:0];
            fwd_ff    <= flags[FL_FWD];
            ilv_ff    <= flags[FL_IDATA] && flags[FL_IFWD];
            rcf_ff    <= flags[FL_RECONF];
            cstart_ff <= cookie_start;
            cbytes_ff <= cookie_bytes;
         end else begin
            tag_ff    <= 32'd0;
            wnd_ff    <= 32'd0;
            obc_ff    <= 16'd0;
            ibc_ff    <= 16'd0;
            tsn_ff    <= 32'd0;
            fwd_ff    <= 1'b0;
            ilv_ff    <= 1'b0;
            rcf_ff    <= 1'b0;
            cstart_ff <= 16'd0;
            cbytes_ff <= 16'd0;
         end
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_status         = status_ff;
   assign rsp_peer_tag       = tag_ff;
   assign rsp_peer_window    = wnd_ff;
   assign rsp_outbound_count = obc_ff;
   assign rsp_inbound_count  = ibc_ff;
   assign rsp_first_tsn      = tsn_ff;
   assign rsp_forward_tsn_ok = fwd_ff;
   assign rsp_interleave_ok  = ilv_ff;
   assign rsp_reconfig_ok    = rcf_ff;
   assign rsp_cookie_start   = cstart_ff;
   assign rsp_cookie_bytes   = cbytes_ff;

endmodule
